### hw/rtl/twj_pkg.sv
// ----------------------------------------------------------------------------
// twj_pkg
// Shared types and constants of the text wrap and justify unit.
// ----------------------------------------------------------------------------
`default_nettype none

package twj_pkg;

  localparam int unsigned MaxWidth   = 62;
  localparam int unsigned CharW      = 8;
  localparam int unsigned WidthW     = 6;   // line width register
  localparam int unsigned LineAddrW  = 6;   // line store, 64 entries
  localparam int unsigned WordAddrW  = 5;   // word bounds, 32 entries
  localparam int unsigned WordCntW   = 6;   // pending word count, 0..32
  localparam int unsigned CountW     = 7;   // character counts
  localparam int unsigned QuotW      = 6;
  localparam int unsigned RemW       = 5;

  localparam logic [CharW-1:0]  ChSpace        = 8'h20;
  localparam logic [CharW-1:0]  ChNewline      = 8'h0A;
  localparam logic [CharW-1:0]  ChError        = 8'h00;
  localparam logic [WidthW-1:0] LineWidthReset = 6'd40;

  typedef enum logic [0:0] {
    CfgLineWidth = 1'b0,
    CfgJustify   = 1'b1
  } cfg_idx_e;

  // Divider result towards the sequencer
  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
    logic [RemW-1:0]  rem;
  } div_res_t;

endpackage

`default_nettype wire

### hw/rtl/text_wrap_justify_unit.sv
// ----------------------------------------------------------------------------
// text_wrap_justify_unit
// Greedy word wrapper with optional full justification over a byte stream.
// ----------------------------------------------------------------------------
// Sequence: a break, newline or error result passes the state register, then
//   the output register; a flushed line's first character follows ST_DIV,
//   ST_WRD_RD, ST_WRD and ST_CHR_RD (after ST_BRK behind a break; ST_DIV waits
//   for the divider when justifying). Throughput: one item at a time; a flushed
//   line reads each word's bounds, each character (line store read, then output
//   register) and each pad space in turn; emitting states stall on back-pressure.
// Reset: control state clears, line width returns to 40, justify to off; the
//   line store and word bounds memories are not cleared.
`default_nettype none

module text_wrap_justify_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] char_in
  input  logic                         s_axis_tlast,   // end_of_text
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [7:0] char_out
  output logic                         m_axis_tlast,   // last_of_run
  output logic                         m_axis_tuser,   // [0] word_too_long
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  twj_pkg::cfg_idx_e            cfg_index_i,
  input  logic [twj_pkg::WidthW-1:0]   cfg_data_i
);
  import twj_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BRK, ST_ERR, ST_DIV, ST_WRD_RD, ST_WRD,
    ST_CHR_RD, ST_CHR_OUT, ST_GAP, ST_NL
  } state_e;

  // Memories: characters of the pending line, and start/end of each word
  logic [CharW-1:0]         line_store [2**LineAddrW];
  logic [2*LineAddrW-1:0]   word_bounds [2**WordAddrW];
  logic [CharW-1:0]         chr_rd_q;
  logic [2*LineAddrW-1:0]   bnd_rd_q;

  // Configuration
  logic [WidthW-1:0] lw_q;
  logic              jen_q;

  // Text state
  logic [WordCntW-1:0]  pw_q, pw_d;
  logic [CountW-1:0]    lcc_q, lcc_d;
  logic [CountW-1:0]    cwl_q, cwl_d;
  logic                 abort_q, abort_d;
  logic                 brk_q, brk_d;
  logic [LineAddrW-1:0] base_q, base_d;   // store address of line start
  logic [LineAddrW-1:0] fill_q, fill_d;   // store address past last word

  // Sequencer
  state_e               state_q;
  logic                 j_err_q, j_line_q, j_nl_q, j_div_q;
  logic [WordCntW-1:0]  l_pw_q;
  logic [WordAddrW-1:0] l_gaps_q;
  logic [QuotW-1:0]     q_q;
  logic [RemW-1:0]      r_q;
  logic [WordCntW-1:0]  k_q;
  logic [LineAddrW-1:0] p_q, e_q;
  logic [CountW-1:0]    sp_q;

  logic             m_valid_q, m_last_q, m_user_q;
  logic [CharW-1:0] m_data_q;

  // Accept-time decode
  logic                 acc, is_ws, is_nl;
  logic [WidthW-1:0]    eff_w;
  logic [CountW-1:0]    ext_w;
  logic                 push_en, emit_en, err_en, nl_en, brk_en, wr_char, wr_bound;
  logic [LineAddrW-1:0] end_abs, fill_a, fill_rel, char_addr;
  logic [WordCntW-1:0]  pw_a;
  logic [WordAddrW-1:0] gaps_a;
  logic [CountW-1:0]    used_a;
  logic [QuotW-1:0]     spare_a;
  logic                 line_en, div_en;
  state_e               acc_next;

  logic     can_load, out_load, last_word, word_end, extra_pad;
  state_e   after_brk;
  div_res_t div_res;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign can_load      = !m_valid_q || m_axis_tready;
  // load the output register in any emitting state once it is free
  assign out_load      = can_load && ((state_q == ST_BRK) || (state_q == ST_ERR) ||
                         (state_q == ST_CHR_OUT) || (state_q == ST_GAP) ||
                         (state_q == ST_NL));

  always_comb begin
    is_nl = (s_axis_tdata == ChNewline);
    is_ws = (s_axis_tdata == ChSpace) || is_nl;
    if (lw_q == '0) begin
      eff_w = WidthW'(1);
    end else if (lw_q > WidthW'(MaxWidth)) begin
      eff_w = WidthW'(MaxWidth);
    end else begin
      eff_w = lw_q;
    end
    ext_w = {1'b0, eff_w};

    push_en = 1'b0; emit_en = 1'b0; err_en = 1'b0; nl_en = 1'b0;
    brk_en  = 1'b0; wr_char = 1'b0;
    lcc_d = lcc_q; cwl_d = cwl_q; abort_d = abort_q; brk_d = brk_q;

    if (s_axis_tlast) begin
      // end of text: flush without a break and start afresh
      if (!abort_q) begin
        push_en = (cwl_q != '0);
        emit_en = 1'b1;
      end
      lcc_d = '0; cwl_d = '0; abort_d = 1'b0; brk_d = 1'b0;
    end else if (!abort_q) begin
      brk_en = brk_q;
      brk_d  = 1'b0;
      if (!is_ws) begin
        if (cwl_q >= ext_w) begin
          err_en = 1'b1; abort_d = 1'b1;
        end else begin
          if (lcc_q >= ext_w) begin
            emit_en = 1'b1; brk_d = 1'b1;
            lcc_d = cwl_q + CountW'(1);
          end else begin
            lcc_d = lcc_q + CountW'(1);
          end
          wr_char = 1'b1;
          cwl_d   = cwl_q + CountW'(1);
        end
      end else if (cwl_q > ext_w) begin
        err_en = 1'b1; abort_d = 1'b1;
      end else begin
        push_en = (cwl_q != '0);
        cwl_d   = '0;
        if (is_nl || lcc_q >= ext_w) begin
          emit_en = 1'b1; nl_en = is_nl; brk_d = 1'b1;
          lcc_d = '0;
        end else if (cwl_q != '0) begin
          lcc_d = lcc_q + CountW'(1);
        end
      end
    end

    end_abs   = fill_q + cwl_q[LineAddrW-1:0];
    char_addr = end_abs;
    wr_bound  = push_en && !pw_q[WordCntW-1];
    fill_a    = wr_bound ? end_abs : fill_q;
    pw_a      = wr_bound ? pw_q + WordCntW'(1) : pw_q;
    pw_d      = (emit_en || s_axis_tlast) ? '0 : pw_a;
    base_d    = (emit_en || s_axis_tlast) ? fill_a : base_q;
    fill_d    = fill_a;

    // spare width of the line being flushed
    fill_rel = fill_a - base_q;
    gaps_a   = WordAddrW'(pw_a - WordCntW'(1));
    used_a   = {1'b0, fill_rel} + {2'b0, gaps_a};
    spare_a  = (ext_w > used_a) ? QuotW'(ext_w - used_a) : '0;
    line_en  = emit_en && (pw_a != '0);
    div_en   = line_en && jen_q && (gaps_a != '0);

    priority if (brk_en)  acc_next = ST_BRK;
    else if (err_en)      acc_next = ST_ERR;
    else if (line_en)     acc_next = ST_DIV;
    else if (nl_en)       acc_next = ST_NL;
    else                  acc_next = ST_IDLE;

    priority if (j_err_q) after_brk = ST_ERR;
    else if (j_line_q)    after_brk = ST_DIV;
    else if (j_nl_q)      after_brk = ST_NL;
    else                  after_brk = ST_IDLE;

    last_word = (k_q == l_pw_q - WordCntW'(1));
    word_end  = (p_q + LineAddrW'(1) == e_q);
    extra_pad = (k_q[WordAddrW-1:0] >= l_gaps_q - r_q);
  end

  twj_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (acc && div_en),
    .dividend_i (spare_a),
    .divisor_i  (gaps_a),
    .res_o      (div_res)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q  <= LineWidthReset;
      jen_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgLineWidth: lw_q  <= cfg_data_i;
        CfgJustify:   jen_q <= cfg_data_i[0];
      endcase
    end
  end

  // Text state: update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q <= '0; lcc_q <= '0; cwl_q <= '0; abort_q <= 1'b0; brk_q <= 1'b0;
      base_q <= '0; fill_q <= '0;
    end else if (acc) begin
      pw_q <= pw_d; lcc_q <= lcc_d; cwl_q <= cwl_d; abort_q <= abort_d;
      brk_q <= brk_d; base_q <= base_d; fill_q <= fill_d;
    end
  end

  // Memories: write at accept, read every cycle at the sequencer's address
  always_ff @(posedge clk_i) begin
    if (acc && wr_char) begin
      line_store[char_addr] <= s_axis_tdata;
    end
    chr_rd_q <= line_store[p_q];
  end

  always_ff @(posedge clk_i) begin
    if (acc && wr_bound) begin
      word_bounds[pw_q[WordAddrW-1:0]] <= {fill_q, end_abs};
    end
    bnd_rd_q <= word_bounds[k_q[WordAddrW-1:0]];
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
      m_user_q  <= 1'b0;
      j_err_q   <= 1'b0;
      j_line_q  <= 1'b0;
      j_nl_q    <= 1'b0;
      j_div_q   <= 1'b0;
      l_pw_q    <= '0;
      l_gaps_q  <= '0;
      q_q       <= '0;
      r_q       <= '0;
      k_q       <= '0;
      p_q       <= '0;
      e_q       <= '0;
      sp_q      <= '0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            j_err_q  <= err_en;
            j_line_q <= line_en;
            j_nl_q   <= nl_en;
            j_div_q  <= div_en;
            l_pw_q   <= pw_a;
            l_gaps_q <= gaps_a;
            k_q      <= '0;
            state_q  <= acc_next;
          end
        end
        ST_BRK: begin
          if (can_load) begin
            m_data_q  <= ChNewline;
            m_user_q  <= 1'b0;
            m_last_q  <= !(j_err_q || j_line_q || j_nl_q);
            state_q   <= after_brk;
          end
        end
        ST_ERR: begin
          if (can_load) begin
            m_data_q  <= ChError;
            m_user_q  <= 1'b1;
            m_last_q  <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        ST_DIV: begin
          // plain spacing: no division, one space per gap
          if (!j_div_q) begin
            q_q     <= '0;
            r_q     <= '0;
            state_q <= ST_WRD_RD;
          end else if (div_res.done) begin
            q_q     <= div_res.quot;
            r_q     <= div_res.rem;
            state_q <= ST_WRD_RD;
          end
        end
        ST_WRD_RD: state_q <= ST_WRD;
        ST_WRD: begin
          p_q     <= bnd_rd_q[2*LineAddrW-1:LineAddrW];
          e_q     <= bnd_rd_q[LineAddrW-1:0];
          state_q <= ST_CHR_RD;
        end
        ST_CHR_RD: state_q <= ST_CHR_OUT;
        ST_CHR_OUT: begin
          if (can_load) begin
            m_data_q  <= chr_rd_q;
            m_user_q  <= 1'b0;
            m_last_q  <= last_word && word_end && !j_nl_q;
            p_q       <= p_q + LineAddrW'(1);
            if (!word_end) begin
              state_q <= ST_CHR_RD;
            end else if (!last_word) begin
              // gap: one space, the even share, and one more on the right
              sp_q    <= CountW'(1) + {1'b0, q_q} + {6'd0, extra_pad};
              state_q <= ST_GAP;
            end else begin
              state_q <= j_nl_q ? ST_NL : ST_IDLE;
            end
          end
        end
        ST_GAP: begin
          if (can_load) begin
            m_data_q  <= ChSpace;
            m_user_q  <= 1'b0;
            m_last_q  <= 1'b0;
            if (sp_q == CountW'(1)) begin
              k_q     <= k_q + WordCntW'(1);
              state_q <= ST_WRD_RD;
            end else begin
              sp_q <= sp_q - CountW'(1);
            end
          end
        end
        ST_NL: begin
          if (can_load) begin
            m_data_q  <= ChNewline;
            m_user_q  <= 1'b0;
            m_last_q  <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

  // Counted line length never passes the widest line
  a_lcc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcc_q <= CountW'(MaxWidth))
    else $error("line count beyond maximum width");

  // An empty pending line starts where the last one ended
  a_empty_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pw_q == '0) |-> (fill_q == base_q))
    else $error("empty line with fill off its base");

  // No break is owed while the text is aborted
  a_abort_brk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    abort_q |-> !brk_q)
    else $error("break owed during abort");

  // An error result is a lone zero byte that closes its run
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_user_q) |-> (m_last_q && m_data_q == ChError))
    else $error("malformed error result");

  // The pending word count never passes the word store depth
  a_pw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pw_q <= WordCntW'(2**WordAddrW))
    else $error("pending word count overflow");

endmodule

`default_nettype wire

### hw/rtl/twj_div.sv
// ----------------------------------------------------------------------------
// twj_div
// Restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module twj_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [twj_pkg::QuotW-1:0]  dividend_i,
  input  logic [twj_pkg::RemW-1:0]   divisor_i,
  output twj_pkg::div_res_t          res_o
);
  import twj_pkg::*;

  logic [2:0]       cnt_q;
  logic             run_q;
  logic             done_q;
  logic [QuotW-1:0] quo_q;
  logic [RemW-1:0]  rem_q;
  logic [RemW-1:0]  dvs_q;
  logic [RemW:0]    trial;
  logic             ge;

  assign trial = {rem_q, quo_q[QuotW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'(QuotW - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[QuotW-2:0], ge};
      rem_q <= ge ? RemW'(trial - {1'b0, dvs_q}) : trial[RemW-1:0];
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q;

endmodule

`default_nettype wire
